[sv/uart_motor_command_decoder_defines.svh]
// assertion macros used by the motor command decoder core
`ifndef UART_MOTOR_COMMAND_DECODER_DEFINES_SVH
`define UART_MOTOR_COMMAND_DECODER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define UMCD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define UMCD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define UMCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/umcd_pkg.sv]
// types, command word table and codes for the motor command decoder
package umcd_pkg;

   localparam int WORD_COUNT = 6;
   localparam int WORD_MAX_LEN = 12;
   localparam logic [7:0] TERMINATOR = 8'h2E;

   // register index of the speed limit
   localparam logic CSR_IDX_SLOWEST = 1'b0;
   localparam logic [7:0] SLOWEST_RESET = 8'd15;

   // command words, bit i of the candidate mask follows this order
   typedef enum logic [2:0] {
      W_START  = 3'd0,
      W_STOP   = 3'd1,
      W_FASTER = 3'd2,
      W_SLOWER = 3'd3,
      W_CW     = 3'd4,
      W_CCW    = 3'd5
   } word_type;

   typedef enum logic [1:0] {
      REPLY_OK        = 2'd0,
      REPLY_MAX_SPEED = 2'd1,
      REPLY_MIN_SPEED = 2'd2
   } reply_type;

   // result of one processed byte
   typedef struct packed {
      logic      fire;
      reply_type reply;
      logic      motor_on;
      logic      turn_ccw;
      logic [7:0] speed;
   } umcd_rsp_type;

   function automatic logic [3:0] word_len(input logic [2:0] w);
      logic [3:0] len;
      case (w)
         W_START:  len = 4'd11;
         W_STOP:   len = 4'd10;
         W_FASTER: len = 4'd9;
         W_SLOWER: len = 4'd12;
         W_CW:     len = 4'd8;
         W_CCW:    len = 4'd9;
         default:  len = 4'd0;
      endcase
      return len;
   endfunction

   // character p of word w, left justified in a 12-character field
   function automatic logic [7:0] word_char(input logic [2:0] w, input logic [3:0] p);
      logic [8*WORD_MAX_LEN-1:0] txt;
      logic [7:0] ch;
      case (w)
         W_START:  txt = {"MOTOR", "_START "};
         W_STOP:   txt = {"MOTOR", "_STOP  "};
         W_FASTER: txt = {"SPEED", "_ADD   "};
         W_SLOWER: txt = {"SPEED", "_REDUCE"};
         W_CW:     txt = {"MOTOR", "_CW    "};
         W_CCW:    txt = {"MOTOR", "_ACW   "};
         default:  txt = '0;
      endcase
      if (p < 4'(WORD_MAX_LEN)) begin
         ch = txt[(WORD_MAX_LEN - 1 - int'(p)) * 8 +: 8];
      end else begin
         ch = 8'd0;
      end
      return ch;
   endfunction

endpackage

[sv/umcd_csr.sv]
// configuration register file on the apb-style port
module umcd_csr
   import umcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  slowest_step
);

   logic [7:0] slowest_ff;
   logic [7:0] slowest_in;
   logic       wr_en;

   assign csr_pready = 1'b1;

   // write on the access phase of a write beat
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == CSR_IDX_SLOWEST);

   always_comb begin
      slowest_in = slowest_ff;
      if (wr_en) begin
         slowest_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slowest_ff <= SLOWEST_RESET;
      end else begin
         slowest_ff <= slowest_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_IDX_SLOWEST) begin
         csr_prdata = {24'd0, slowest_ff};
      end
   end

   assign slowest_step = slowest_ff;

endmodule

[sv/umcd_core.sv]
// command matcher and motor state update, one byte per step
`include "uart_motor_command_decoder_defines.svh"

module umcd_core
   import umcd_pkg::*;
#(
   parameter int BUF_LEN = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   rx_byte,
   input  logic [7:0]   slowest_step,
   output umcd_rsp_type rsp
);

   localparam int POS_CAP = ((BUF_LEN - 1) < 127) ? (BUF_LEN - 1) : 127;
   localparam int POS_W = $clog2(POS_CAP + 1);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [WORD_COUNT-1:0] alive_ff, alive_in;
   logic                  motor_ff, motor_in;
   logic                  ccw_ff, ccw_in;
   logic [7:0]            speed_ff, speed_in;

   logic                  is_term;
   logic [WORD_COUNT-1:0] char_ok;
   logic [WORD_COUNT-1:0] len_ok;
   logic                  hit;
   logic [2:0]            hit_word;
   reply_type             reply;

   assign is_term = (rx_byte == TERMINATOR);

   // per-word compare of this byte and of the gathered length
   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         len_ok[i]  = (pos_ff == POS_W'(word_len(3'(i))));
         char_ok[i] = (pos_ff < POS_W'(word_len(3'(i))))
                      && (word_char(3'(i), pos_ff[3:0]) == rx_byte);
      end
   end

   // first live candidate whose length matches
   always_comb begin
      hit = 1'b0;
      hit_word = W_START;
      for (int i = WORD_COUNT - 1; i >= 0; i--) begin
         if (alive_ff[i] && len_ok[i]) begin
            hit = 1'b1;
            hit_word = 3'(i);
         end
      end
   end

   // next state
   always_comb begin
      pos_in   = pos_ff;
      alive_in = alive_ff;
      motor_in = motor_ff;
      ccw_in   = ccw_ff;
      speed_in = speed_ff;
      reply    = REPLY_OK;
      if (step) begin
         if (!is_term) begin
            alive_in = alive_ff & char_ok;
            if (pos_ff < POS_W'(POS_CAP)) begin
               pos_in = pos_ff + 1'b1;
            end
         end else begin
            pos_in   = '0;
            alive_in = '1;
            if (hit) begin
               case (hit_word)
                  W_START:  motor_in = 1'b1;
                  W_STOP:   motor_in = 1'b0;
                  W_FASTER: begin
                     if (speed_ff != 8'd0) begin
                        speed_in = speed_ff - 8'd1;
                     end else begin
                        reply = REPLY_MAX_SPEED;
                     end
                  end
                  W_SLOWER: begin
                     if (speed_ff < slowest_step) begin
                        speed_in = speed_ff + 8'd1;
                     end else begin
                        reply = REPLY_MIN_SPEED;
                     end
                  end
                  W_CW:     ccw_in = 1'b0;
                  W_CCW:    ccw_in = 1'b1;
                  default:  ccw_in = ccw_ff;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         alive_ff <= '1;
         motor_ff <= 1'b0;
         ccw_ff   <= 1'b0;
         speed_ff <= 8'd0;
      end else begin
         pos_ff   <= pos_in;
         alive_ff <= alive_in;
         motor_ff <= motor_in;
         ccw_ff   <= ccw_in;
         speed_ff <= speed_in;
      end
   end

   // result of this byte, state after the command
   assign rsp.fire     = step && is_term && hit;
   assign rsp.reply    = reply;
   assign rsp.motor_on = motor_in;
   assign rsp.turn_ccw = ccw_in;
   assign rsp.speed    = speed_in;

   // checks
   `UMCD_ASSERT_ALWAYS(a_pos_cap, clock, reset, pos_ff <= POS_W'(POS_CAP), "position past cap")
   `UMCD_ASSERT_NEXT(a_term_clears, clock, reset, step && is_term, pos_ff == '0 && alive_ff == '1, "terminator did not clear command")
   `UMCD_ASSERT_NEXT(a_idle_holds, clock, reset, !step, $stable(speed_ff) && $stable(pos_ff) && $stable(motor_ff), "state moved without a byte")

endmodule

[sv/uart_motor_command_decoder.sv]
// top level of the serial motor command decoder
// Takes one received byte per beat and gathers a command up to a period, then
// matches it against the six command words (motor start, motor stop, speed up,
// slow down, clockwise and counter-clockwise). A recognized command yields one
// result beat with the reply code and the motor state after the command; an unknown
// command yields nothing and clears the gathered text. An accepted period sits in the
// input register while the matcher works on it, and the result register loads from the
// matcher's output when the period steps. One byte is accepted every cycle; a period
// waits in the input register only while a previous result is still held and not
// taken. The speed limit register sits at byte address 0.
module uart_motor_command_decoder
   import umcd_pkg::*;
#(
   parameter int BUF_LEN = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_code,
   output logic        rsp_motor_on,
   output logic        rsp_turn_ccw,
   output logic [7:0]  rsp_speed_step,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   logic         out_valid_ff, out_valid_in;
   logic [1:0]   out_reply_ff, out_reply_in;
   logic         out_motor_ff, out_motor_in;
   logic         out_ccw_ff, out_ccw_in;
   logic [7:0]   out_speed_ff, out_speed_in;

   logic         step;
   logic [7:0]   slowest_step;
   umcd_rsp_type core_rsp;

   umcd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .slowest_step (slowest_step)
   );

   // a byte moves on unless it is a period and the result slot is busy
   assign step = in_valid_ff
                 && ((in_byte_ff != TERMINATOR) || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   umcd_core #(
      .BUF_LEN (BUF_LEN)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .slowest_step (slowest_step),
      .rsp          (core_rsp)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_reply_in = out_reply_ff;
      out_motor_in = out_motor_ff;
      out_ccw_in   = out_ccw_ff;
      out_speed_in = out_speed_ff;
      if (core_rsp.fire) begin
         out_valid_in = 1'b1;
         out_reply_in = core_rsp.reply;
         out_motor_in = core_rsp.motor_on;
         out_ccw_in   = core_rsp.turn_ccw;
         out_speed_in = core_rsp.speed;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_reply_ff <= out_reply_in;
      out_motor_ff <= out_motor_in;
      out_ccw_ff   <= out_ccw_in;
      out_speed_ff <= out_speed_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_reply_code = out_reply_ff;
   assign rsp_motor_on   = out_motor_ff;
   assign rsp_turn_ccw   = out_ccw_ff;
   assign rsp_speed_step = out_speed_ff;

endmodule
